// File: sv/frsm_pkg.sv
package frsm_pkg;

	// Field widths.
	localparam int TIME_W = 32;
	localparam int RATE_W = 16;
	localparam int SEG_W  = 8;
	localparam int LOW_W  = 24;

	// Rate in hundredths of a frame per second is RATE_SCALE / elapsed.
	localparam logic [26:0] RATE_SCALE = 27'd100000000;
	localparam logic [RATE_W-1:0] RATE_MAX = 16'hFFFF;

	// Any elapsed time below this gives a quotient above RATE_MAX.
	localparam logic [TIME_W-1:0] SAT_LIMIT = 32'd1526;

	// The quotient has RATE_W bits, so the division takes RATE_W steps.
	localparam int DIV_STEPS = RATE_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int DIGITS    = 4;

	// Reciprocal of ten, exact for every 16-bit value.
	localparam logic [RATE_W-1:0] RECIP_TEN   = 16'd52429;
	localparam int                RECIP_SHIFT = 19;

	localparam logic [SEG_W-1:0] DP_BIT = 8'h80;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 2;

	// One classified request on its way to the back end.
	typedef struct packed {
		logic [TIME_W-1:0] elapsed;
		logic              sat;
	} frsm_item_t;

	// Active-low segment pattern of one decimal digit, decimal point off.
	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = 8'hFF;
		endcase
		return s;
	endfunction

endpackage

// File: sv/frsm_if.sv
// Measurement channel: two timer readings per request.
interface frsm_in_if import frsm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] start_time;
	logic [TIME_W-1:0] end_time;

	modport source (output valid, start_time, end_time, input ready);
	modport sink (input valid, start_time, end_time, output ready);
endinterface

// Display channel: segment words and the saturation flag.
interface frsm_out_if import frsm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LOW_W-1:0] low_digits_word;
	logic [SEG_W-1:0] high_digit_word;
	logic             saturated;

	modport source (output valid, low_digits_word, high_digit_word, saturated, input ready);
	modport sink (input valid, low_digits_word, high_digit_word, saturated, output ready);
endinterface

// File: sv/frsm_front.sv
module frsm_front import frsm_pkg::*; (
	frsm_in_if.sink    meas,
	output frsm_item_t push_item,
	output logic       push_valid,
	input  logic       push_ready
);

	logic [TIME_W-1:0] elapsed;

	// Elapsed time wraps with the timer.
	assign elapsed = meas.end_time - meas.start_time;

	// Short intervals, zero included, overflow the 16-bit rate.
	assign push_item.elapsed = elapsed;
	assign push_item.sat     = (elapsed < SAT_LIMIT);

	assign push_valid = meas.valid;
	assign meas.ready = push_ready;

endmodule

// File: sv/frsm_queue.sv
module frsm_queue import frsm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  frsm_item_t push_item,
	input  logic       push_valid,
	output logic       push_ready,
	output frsm_item_t pop_item,
	output logic       pop_valid,
	input  logic       pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	frsm_item_t              slot_q [DEPTH];
	logic [PTR_W-1:0]        wptr_q;
	logic [PTR_W-1:0]        rptr_q;
	logic [FILL_W-1:0]       fill_q;
	logic                    do_push;
	logic                    do_pop;

	assign push_ready = (fill_q != FILL_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_item   = slot_q[rptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/frsm_back.sv
module frsm_back import frsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frsm_item_t  pop_item,
	input  logic        pop_valid,
	output logic        pop,
	frsm_out_if.source  disp
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_DIGIT = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	logic [1:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [TIME_W-1:0]       divisor_q;
	logic [TIME_W-1:0]       rem_q;
	logic [RATE_W-1:0]       work_q;
	logic                    sat_q;
	logic [DIGITS*SEG_W-1:0] segs_q;

	logic                    out_valid_q;
	logic [LOW_W-1:0]        low_q;
	logic [SEG_W-1:0]        high_q;
	logic                    out_sat_q;

	logic [TIME_W:0]         trial;
	logic                    q_bit;
	logic [TIME_W:0]         trial_diff;
	logic [2*RATE_W-1:0]     prod;
	logic [RATE_W-1:0]       quo;
	logic [RATE_W-1:0]       ten_quo;
	logic [RATE_W-1:0]       digit_full;
	logic [SEG_W-1:0]        seg;
	logic                    out_free;

	// One restoring division step: bring in the next dividend bit.
	assign trial      = {rem_q, work_q[RATE_W-1]};
	assign trial_diff = trial - {1'b0, divisor_q};
	assign q_bit      = (trial >= {1'b0, divisor_q});

	// One decimal digit per step through a reciprocal multiply.
	assign prod       = work_q * RECIP_TEN;
	assign quo        = RATE_W'(prod >> RECIP_SHIFT);
	assign ten_quo    = (quo << 3) + (quo << 1);
	assign digit_full = work_q - ten_quo;
	assign seg        = seg_of(digit_full[3:0]) | DP_BIT;

	assign out_free = !out_valid_q || disp.ready;
	assign pop      = (state_q == ST_IDLE) && pop_valid;

	// Sequencer for division and digit split.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (pop_valid) begin
						state_q <= pop_item.sat ? ST_DIGIT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DIGIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIGIT: begin
					if (cnt_q == CNT_W'(DIGITS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_HOLD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the divider and digit split.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				divisor_q <= pop_item.elapsed;
				sat_q     <= pop_item.sat;
				// The top dividend bits already sit below any valid divisor.
				rem_q     <= TIME_W'(RATE_SCALE >> RATE_W);
				work_q    <= pop_item.sat ? RATE_MAX : RATE_SCALE[RATE_W-1:0];
			end
			ST_DIV: begin
				rem_q  <= q_bit ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
				work_q <= {work_q[RATE_W-2:0], q_bit};
			end
			ST_DIGIT: begin
				work_q <= quo;
				segs_q <= {seg, segs_q[DIGITS*SEG_W-1:SEG_W]};
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (disp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hundreds digit carries the lit decimal point.
	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			low_q     <= {segs_q[3*SEG_W-1:2*SEG_W] & ~DP_BIT, segs_q[2*SEG_W-1:0]};
			high_q    <= segs_q[4*SEG_W-1:3*SEG_W];
			out_sat_q <= sat_q;
		end
	end

	assign disp.valid           = out_valid_q;
	assign disp.low_digits_word = low_q;
	assign disp.high_digit_word = high_q;
	assign disp.saturated       = out_sat_q;

endmodule

// File: sv/frame_rate_seven_segment_meter_top.sv
// Frame-rate meter: 100000000 / (end_time - start_time) shown on four seven-segment digits.
// Each request passes through the queue, the 16-step divider (skipped when saturated), the digit split
// and the hold state into the output register; the back end takes one request at a time, and
// a two-entry queue lets the front accept new requests while the back end works.
// Reset is asynchronous and active low; it empties the queue and the output register.
module frame_rate_seven_segment_meter_top import frsm_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	frsm_in_if.sink     meas,
	frsm_out_if.source  disp
);

	frsm_item_t push_item;
	logic       push_valid;
	logic       push_ready;
	frsm_item_t pop_item;
	logic       pop_valid;
	logic       pop;

	frsm_front u_front (
		.meas       (meas),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	frsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop        (pop)
	);

	frsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_item  (pop_item),
		.pop_valid (pop_valid),
		.pop       (pop),
		.disp      (disp)
	);

endmodule

// File: sv/frsm_checker.sv
module frsm_checker import frsm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [LOW_W-1:0] low_digits_word,
	input logic [SEG_W-1:0] high_digit_word,
	input logic             saturated
);

	// A stalled result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(low_digits_word) && $stable(high_digit_word)
			&& $stable(saturated))
		else $error("result changed while stalled");

	// Only the hundreds digit shows a decimal point.
	a_dp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !low_digits_word[23] && low_digits_word[15] && low_digits_word[7]
			&& high_digit_word[7])
		else $error("decimal point misplaced");

	// A saturated rate reads 55.35 on the display.
	a_sat_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> low_digits_word == 24'h12B092 && high_digit_word == 8'h92)
		else $error("saturated result has wrong digits");

endmodule

bind frame_rate_seven_segment_meter_top frsm_checker u_frsm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (disp.valid),
	.out_ready       (disp.ready),
	.low_digits_word (disp.low_digits_word),
	.high_digit_word (disp.high_digit_word),
	.saturated       (disp.saturated)
);

// File: tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import frsm_pkg::*;

	localparam int PRINT_CAP = 40;
	localparam int PHASE_REQUESTS = 430;
	localparam int HOLD_CYCLES = 300;
	localparam int unsigned RATE_NUMERATOR = 100000000;
	localparam int unsigned RATE_CEILING = 65535;

	// Active-low patterns for digits 0..9, segment a in bit 0, decimal point off.
	localparam logic [SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	typedef struct {
		logic [LOW_W-1:0] low;
		logic [SEG_W-1:0] high;
		logic             sat;
	} display_t;

	// Predicts the display words for each accepted request and checks results in order.
	class fps_scoreboard;
		display_t expected_q[$];
		int mismatches;
		int results;
		int saturations;
		int wraps;

		function int outstanding();
			return expected_q.size();
		endfunction

		function void note_request(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e);
			logic [TIME_W-1:0] elapsed;
			int unsigned rate;
			display_t d;
			elapsed = e - s;
			d.sat = 1'b0;
			if (elapsed == 0) begin
				rate = RATE_CEILING;
				d.sat = 1'b1;
			end else begin
				rate = RATE_NUMERATOR / elapsed;
				if (rate > RATE_CEILING) begin
					rate = RATE_CEILING;
					d.sat = 1'b1;
				end
			end
			// The ten-thousands digit is dropped; the hundreds digit carries the lit point.
			d.high = DIGIT_SEGMENTS[(rate / 1000) % 10];
			d.low = {DIGIT_SEGMENTS[(rate / 100) % 10] & ~DP_BIT,
				DIGIT_SEGMENTS[(rate / 10) % 10], DIGIT_SEGMENTS[rate % 10]};
			if (d.sat)
				saturations++;
			if (e < s)
				wraps++;
			expected_q.push_back(d);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t ns mismatch: %s", $time, msg);
		endtask

		task check_result(logic [LOW_W-1:0] low, logic [SEG_W-1:0] high, logic sat);
			display_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("display result arrived with no request pending");
				return;
			end
			want = expected_q.pop_front();
			results++;
			if (low !== want.low)
				report_mismatch($sformatf("low_digits_word %06h, expected %06h", low, want.low));
			if (high !== want.high)
				report_mismatch($sformatf("high_digit_word %02h, expected %02h", high, want.high));
			if (sat !== want.sat)
				report_mismatch($sformatf("saturated %b, expected %b", sat, want.sat));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int rx_stall_pct = 0;
	int display_hold_req = 0;
	bit offer_up = 0;
	fps_scoreboard sb = new;

	frsm_in_if meas ();
	frsm_out_if disp ();

	frame_rate_seven_segment_meter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas),
		.disp   (disp)
	);

	// Free-running 4 ns clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#4000000;
		$display("Timed out with %0d results still pending.", sb.outstanding());
		$display("[frame_rate_seven_segment_meter_top] ERROR");
		$finish;
	end

	// Watch both channels for handshakes on each rising edge.
	always @(posedge clk) begin
		if (arst_n && $isunknown(disp.valid))
			sb.report_mismatch("display valid is unknown");
		if (arst_n && meas.valid && meas.ready)
			sb.note_request(meas.start_time, meas.end_time);
		if (arst_n && disp.valid && disp.ready)
			sb.check_result(disp.low_digits_word, disp.high_digit_word, disp.saturated);
	end

	// Display side: random stalls, plus a long hold-off counted here when asked.
	initial begin
		int hold_left;
		hold_left = 0;
		disp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (display_hold_req != 0) begin
				hold_left = display_hold_req;
				display_hold_req = 0;
			end
			if (hold_left > 0) begin
				disp.ready <= 1'b0;
				hold_left--;
			end else begin
				disp.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Offer one request and wait until the block takes it.
	task automatic send_request(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e);
		meas.valid <= 1'b1;
		meas.start_time <= s;
		meas.end_time <= e;
		offer_up = 1;
		@(posedge clk);
		while (!meas.ready)
			@(posedge clk);
	endtask

	task automatic lower_valid();
		if (offer_up) begin
			meas.valid <= 1'b0;
			offer_up = 0;
		end
	endtask

	task automatic idle_sender(input int pct);
		while ($urandom_range(99) < pct) begin
			lower_valid();
			@(posedge clk);
		end
	endtask

	// Waits for the last result, then returns on a rising edge so driving stays aligned.
	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (sb.outstanding() != 0);
		@(posedge clk);
	endtask

	// Timer readings whose difference spans saturation, realistic rates and huge gaps.
	task automatic random_request(output logic [TIME_W-1:0] s, output logic [TIME_W-1:0] e);
		int unsigned pick;
		int unsigned elapsed;
		pick = $urandom_range(99);
		s = $urandom();
		if (pick < 10)
			elapsed = $urandom_range(1600);
		else if (pick < 30)
			elapsed = $urandom_range(20000, 1526);
		else if (pick < 60)
			elapsed = $urandom_range(1000000, 20000);
		else if (pick < 90)
			elapsed = $urandom_range(110000000, 1000000);
		else
			elapsed = $urandom();
		e = s + elapsed;
	endtask

	// One flow-control mix; optionally a long display hold-off partway through.
	task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
			input bit with_hold);
		logic [TIME_W-1:0] s;
		logic [TIME_W-1:0] e;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == count / 3)
				display_hold_req = HOLD_CYCLES;
			random_request(s, e);
			send_request(s, e);
			if (i == (2 * count) / 3) begin
				lower_valid();
				wait_until_drained();
			end else begin
				idle_sender(tx_pct);
			end
		end
	endtask

	initial begin
		meas.valid <= 1'b0;
		meas.start_time <= '0;
		meas.end_time <= '0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: zero elapsed, the saturation edge, wraps, tiny rates, digit mixes.
		send_request(32'h0000_0000, 32'h0000_0000);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'h0000_0000, 32'h0000_0001);
		send_request(32'd1000, 32'd2525);
		send_request(32'd0, 32'd1526);
		send_request(32'd5, 32'd1532);
		send_request(32'h0000_0000, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'h0000_0000);
		send_request(32'hFFFF_FFF0, 32'h0000_0010);
		send_request(32'hFFFF_0000, 32'hFFFF_0000 + 32'd100000000);
		send_request(32'd123, 32'd100000124);
		send_request(32'd0, 32'd99999999);
		send_request(32'd0, 32'd10000);
		send_request(32'd0, 32'd9999);
		send_request(32'd0, 32'd10001);
		send_request(32'd0, 32'd16667);
		send_request(32'd0, 32'd81037);
		send_request(32'd0, 32'd17612);
		send_request(32'd0, 32'd1666667);
		send_request(32'hAAAA_AAAA, 32'h5555_5555);
		send_request(32'h5555_5555, 32'hAAAA_AAAA);
		send_request(32'd0, 32'd33333333);
		send_request(32'd0, 32'd2000);
		lower_valid();
		wait_until_drained();

		// Random traffic under each flow-control mix.
		run_phase(0, 0, PHASE_REQUESTS, 1);
		run_phase(52, 0, PHASE_REQUESTS, 0);
		run_phase(0, 52, PHASE_REQUESTS, 0);
		run_phase(22, 22, PHASE_REQUESTS, 0);

		lower_valid();
		wait_until_drained();
		repeat (40) @(posedge clk);

		$display("Checked %0d display results: %0d saturated, %0d across a timer wrap.",
			sb.results, sb.saturations, sb.wraps);
		$display("Traffic ran with no idling, sender gaps, display stalls, both, and a long hold-off.");
		if (sb.mismatches == 0) begin
			$display("[frame_rate_seven_segment_meter_top] OK");
		end else begin
			$display("%0d mismatches found.", sb.mismatches);
			$display("[frame_rate_seven_segment_meter_top] ERROR");
		end
		$finish;
	end

endmodule
